>>> hw/rtl/ssmd_pkg.sv
// ----------------------------------------------------------------------------
// ssmd_pkg
// Shared types, codes and the character decoder for the seven-segment
// shift-register display driver.
// ----------------------------------------------------------------------------
package ssmd_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned PosW    = 3;
  localparam int unsigned SegW    = 8;
  localparam int unsigned PhaseW  = 6;

  // Item action codes.
  localparam logic [ActionW-1:0] ActTick     = 3'd0;
  localparam logic [ActionW-1:0] ActSetPat   = 3'd1;
  localparam logic [ActionW-1:0] ActSetChar  = 3'd2;
  localparam logic [ActionW-1:0] ActSetDot   = 3'd3;
  localparam logic [ActionW-1:0] ActClearAll = 3'd4;

  // One digit is 16 bit phases pairs (32 phases), then latch low and latch high.
  localparam logic [PhaseW-1:0] PhaseLatchLo = 6'd32;
  localparam logic [PhaseW-1:0] PhaseLatchHi = 6'd33;

  localparam logic [SegW-1:0] BlankPattern = 8'hFF;
  localparam logic [SegW-1:0] DashPattern  = 8'b1011_1111;
  localparam logic [SegW-1:0] DotClearMask = 8'h7F;
  localparam logic [SegW-1:0] SelectorBase = 8'h08;

  typedef struct packed {
    logic data;
    logic sclk;
    logic latch;
    logic done;
  } pins_t;

  function automatic logic [SegW-1:0] decode_char(input logic [7:0] c);
    logic [SegW-1:0] seg;
    case (c)
      8'h30:   seg = 8'b1100_0000;
      8'h31:   seg = 8'b1111_1001;
      8'h32:   seg = 8'hA4;
      8'h33:   seg = 8'hB0;
      8'h34:   seg = 8'h99;
      8'h35:   seg = 8'h92;
      8'h36:   seg = 8'h82;
      8'h37:   seg = 8'hF8;
      8'h38:   seg = 8'b1000_0000;
      8'h39:   seg = 8'b1001_0000;
      8'h2D:   seg = DashPattern;
      default: seg = BlankPattern;
    endcase
    return seg;
  endfunction

endpackage

>>> hw/rtl/ssmd_phase_gen.sv
// ----------------------------------------------------------------------------
// ssmd_phase_gen
// Turns the digit's 16-bit frame word and the scan phase into pin levels.
// ----------------------------------------------------------------------------
module ssmd_phase_gen (
  input  logic [15:0]                 word_i,
  input  logic [ssmd_pkg::PhaseW-1:0] phase_i,
  output ssmd_pkg::pins_t             pins_o
);
  import ssmd_pkg::*;

  logic [3:0] bit_idx;

  assign bit_idx = 4'd15 - phase_i[4:1];

  always_comb begin
    if (phase_i < PhaseLatchLo) begin
      pins_o.data  = word_i[bit_idx];
      pins_o.sclk  = phase_i[0];
      pins_o.latch = 1'b1;
      pins_o.done  = 1'b0;
    end else begin
      // The data line keeps the last selector bit during the latch pulse.
      pins_o.data  = word_i[0];
      pins_o.sclk  = 1'b1;
      pins_o.latch = (phase_i == PhaseLatchHi);
      pins_o.done  = (phase_i == PhaseLatchHi);
    end
  end

endmodule

>>> hw/rtl/seven_segment_mux_shift_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_mux_shift_driver
// Multiplexed seven-segment display driver feeding two chained shift registers.
// ----------------------------------------------------------------------------
// Writes update the digit store in the cycle they are accepted, and each
// tick computes one pin phase from the scan counters and the store and
// places it in the output register. A new item is accepted each cycle as
// long as the output register is empty or being drained. One digit takes
// 34 ticks: 16 bits of two phases each, then latch low and latch high; the
// full scan is 34 * NUM_DIGITS ticks.
module seven_segment_mux_shift_driver #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ssmd_pkg::ActionW-1:0]  action_i,
  input  logic [ssmd_pkg::PosW-1:0]     position_i,
  input  logic [ssmd_pkg::SegW-1:0]     pattern_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          dot_on_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          data_pin_o,
  output logic                          shift_clock_pin_o,
  output logic                          latch_pin_o,
  output logic                          digit_done_o
);
  import ssmd_pkg::*;

  localparam int unsigned DigitW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [DigitW-1:0] LastDigit = DigitW'(NUM_DIGITS - 1);

  logic [SegW-1:0]     pat_q [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] dot_q;
  logic [DigitW-1:0]   digit_q;
  logic [PhaseW-1:0]   phase_q;
  logic                out_valid_q;
  pins_t               pins_q;

  logic                accept;
  logic                pos_ok;
  logic [DigitW-1:0]   wr_idx;
  logic [SegW-1:0]     seg;
  logic [SegW-1:0]     sel;
  logic [15:0]         word;
  logic [PhaseW-1:0]   phase_eff;
  pins_t               pins_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_ok     = ({1'b0, position_i} < 4'(NUM_DIGITS));
  assign wr_idx     = DigitW'(position_i);

  assign phase_eff = (phase_q > PhaseLatchHi) ? '0 : phase_q;
  assign seg       = dot_q[digit_q] ? (pat_q[digit_q] & DotClearMask) : pat_q[digit_q];
  assign sel       = SelectorBase >> digit_q;
  assign word      = {seg, sel};

  ssmd_phase_gen u_phase_gen (
    .word_i  (word),
    .phase_i (phase_eff),
    .pins_o  (pins_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        pat_q[i] <= BlankPattern;
      end
      dot_q   <= '0;
      digit_q <= '0;
      phase_q <= '0;
    end else if (accept) begin
      case (action_i)
        ActTick: begin
          if (phase_eff == PhaseLatchHi) begin
            phase_q <= '0;
            digit_q <= (digit_q == LastDigit) ? '0 : digit_q + 1'b1;
          end else begin
            phase_q <= phase_eff + 1'b1;
          end
        end
        ActSetPat: begin
          if (pos_ok) begin
            pat_q[wr_idx] <= pattern_i;
          end
        end
        ActSetChar: begin
          if (pos_ok) begin
            pat_q[wr_idx] <= decode_char(char_code_i);
          end
        end
        ActSetDot: begin
          if (pos_ok) begin
            dot_q[wr_idx] <= dot_on_i;
          end
        end
        ActClearAll: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            pat_q[i] <= BlankPattern;
          end
          dot_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded by a tick, emptied when the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && (action_i == ActTick)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ActTick)) begin
      pins_q <= pins_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_pin_o        = pins_q.data;
  assign shift_clock_pin_o = pins_q.sclk;
  assign latch_pin_o       = pins_q.latch;
  assign digit_done_o      = pins_q.done;

endmodule
